// File: rtl/three_wheel_steer_command_top_defines.svh
// Assertion macros for the steering command block
`ifndef THREE_WHEEL_STEER_COMMAND_TOP_DEFINES_SVH
`define THREE_WHEEL_STEER_COMMAND_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define TWS_ASSERT_IMPL(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define TWS_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define TWS_ASSERT_IMPL(label, clk, rst_n, a, c)
`define TWS_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

// File: rtl/tws_pkg.sv
`default_nettype none
package tws_pkg;
    localparam int unsigned CordicIterDefault = 14;
    localparam int unsigned AtanEntries = 21;
    localparam logic [14:0] AngPi = 15'd25736;
    localparam logic [14:0] AngHalfPi = 15'd12868;
    localparam logic [15:0] GainQ16 = 16'd39797;
    // Vector width: 18 bit component, times 16, plus CORDIC growth
    localparam int unsigned VecW = 25;

    typedef enum logic [1:0] {
        MODE_STOP   = 2'd0,
        MODE_RESET  = 2'd1,
        MODE_NORMAL = 2'd2,
        MODE_UNUSED = 2'd3
    } t_mode;

    localparam logic [0:0] REG_BEND_EN = 1'b0;
    localparam logic [0:0] REG_RADIUS  = 1'b1;

    // Per-wheel CORDIC lane state
    typedef struct packed {
        logic signed [VecW-1:0] x;
        logic signed [VecW-1:0] y;
        logic signed [15:0]     z;
        logic                   neg;
        logic                   zero;
    } t_lane;

    function automatic logic signed [15:0] atan_q13(input int unsigned i);
        logic signed [15:0] r;
        case (i)
            0:  r = 16'sd6434;
            1:  r = 16'sd3798;
            2:  r = 16'sd2007;
            3:  r = 16'sd1019;
            4:  r = 16'sd511;
            5:  r = 16'sd256;
            6:  r = 16'sd128;
            7:  r = 16'sd64;
            8:  r = 16'sd32;
            9:  r = 16'sd16;
            10: r = 16'sd8;
            11: r = 16'sd4;
            12: r = 16'sd2;
            13: r = 16'sd1;
            default: r = 16'sd0;
        endcase
        return r;
    endfunction
endpackage
`default_nettype wire

// File: rtl/tws_cordic_stage.sv
`default_nettype none
// One vectoring CORDIC micro-rotation, registered
module tws_cordic_stage #(
    parameter int unsigned Shift = 0
) (
    input  wire                 i_clk,
    input  wire                 i_en,
    input  tws_pkg::t_lane      i_lane,
    output tws_pkg::t_lane      o_lane
);
    tws_pkg::t_lane r_lane;
    tws_pkg::t_lane n_lane;

    // Rotate toward the x axis and accumulate angle
    always_comb begin
        n_lane = i_lane;
        if (i_lane.y >= 0) begin
            n_lane.x = i_lane.x + (i_lane.y >>> Shift);
            n_lane.y = i_lane.y - (i_lane.x >>> Shift);
            n_lane.z = i_lane.z + tws_pkg::atan_q13(Shift);
        end else begin
            n_lane.x = i_lane.x - (i_lane.y >>> Shift);
            n_lane.y = i_lane.y + (i_lane.x >>> Shift);
            n_lane.z = i_lane.z - tws_pkg::atan_q13(Shift);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane <= n_lane;
        end
    end

    assign o_lane = r_lane;
endmodule
`default_nettype wire

// File: rtl/tws_wheel_post.sv
`default_nettype none
// Gain correction, fold sign, bend scaling and saturation, four stages
module tws_wheel_post (
    input  wire                 i_clk,
    input  wire                 i_en,
    input  tws_pkg::t_lane      i_lane,
    input  wire                 i_scale,
    input  wire signed [11:0]   i_num,
    input  wire        [11:0]   i_den,
    input  wire        [15:0]   i_recip,
    output logic       [14:0]   o_angle,
    output logic signed [15:0]  o_speed
);
    // Stage A: gain multiply and angle clamp
    logic signed [41:0] r_prod;
    logic        [14:0] r_ang_a;
    logic               r_neg_a;
    logic               r_zero_a;
    logic        [14:0] n_ang;

    always_comb begin
        if (i_lane.z < 16'sd1) begin
            n_ang = 15'd1;
        end else if (i_lane.z > $signed({1'b0, tws_pkg::AngPi})) begin
            n_ang = tws_pkg::AngPi;
        end else begin
            n_ang = i_lane.z[14:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod   <= 42'(i_lane.x) * $signed({1'b0, tws_pkg::GainQ16});
            r_ang_a  <= i_lane.zero ? tws_pkg::AngPi : n_ang;
            r_neg_a  <= i_lane.neg;
            r_zero_a <= i_lane.zero;
        end
    end

    // Stage B: round magnitude, multiply by |num|
    logic [21:0] w_mag;
    logic [11:0] w_absn;
    logic [32:0] r_p2;
    logic [14:0] r_ang_b;
    logic        r_sneg_b;
    assign w_mag  = 22'((r_prod + 42'sd524288) >>> 20);
    assign w_absn = i_num[11] ? 12'(-i_num) : 12'(i_num);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ang_b <= r_ang_a;
            if (r_zero_a) begin
                r_p2     <= '0;
                r_sneg_b <= 1'b0;
            end else if (i_scale) begin
                // 2*a*|n| + den
                r_p2 <= 33'({w_mag, 1'b0}) * 33'(w_absn) + 33'(i_den);
                r_sneg_b <= r_neg_a ^ (i_num < 0);
            end else begin
                r_p2     <= 33'(w_mag);
                r_sneg_b <= r_neg_a;
            end
        end
    end

    // Stage C: estimate quotient of p2 / (2*den) via reciprocal
    logic        r_scale_b;
    logic [11:0] r_den_b;
    logic [15:0] r_recip_b;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_scale_b <= i_scale & ~r_zero_a;
            r_den_b   <= i_den;
            r_recip_b <= i_recip;
        end
    end

    logic [48:0] w_qm;
    logic [22:0] w_q0;
    logic [12:0] w_d2;
    assign w_d2  = {r_den_b, 1'b0};
    assign w_qm  = 49'(r_p2) * 49'(r_recip_b);
    // Reciprocal under-estimates: q0 is q or q-1 or q-2
    assign w_q0  = 23'(w_qm >> 26);

    logic [22:0] r_q0;
    logic [32:0] r_p2_c;
    logic [12:0] r_d2_c;
    logic        r_scale_c;
    logic        r_sneg_c;
    logic [14:0] r_ang_c;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q0      <= w_q0;
            r_p2_c    <= r_p2;
            r_d2_c    <= w_d2;
            r_scale_c <= r_scale_b;
            r_sneg_c  <= r_sneg_b;
            r_ang_c   <= r_ang_b;
        end
    end

    // Stage D: correct quotient with the remainder, apply sign, saturate
    logic [35:0] w_rem;
    logic [22:0] w_q;
    logic signed [24:0] w_s;
    assign w_rem = 36'(r_p2_c) - 36'(r_q0) * 36'(r_d2_c);

    always_comb begin
        if (!r_scale_c) begin
            w_q = r_p2_c[22:0];
        end else if (w_rem >= 36'({r_d2_c, 1'b0})) begin
            w_q = r_q0 + 23'd2;
        end else if (w_rem >= 36'(r_d2_c)) begin
            w_q = r_q0 + 23'd1;
        end else begin
            w_q = r_q0;
        end
        w_s = r_sneg_c ? -$signed({2'b00, w_q}) : $signed({2'b00, w_q});
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_angle <= r_ang_c;
            if (w_s > 25'sd32767) begin
                o_speed <= 16'sh7FFF;
            end else if (w_s < -25'sd32768) begin
                o_speed <= 16'sh8000;
            end else begin
                o_speed <= w_s[15:0];
            end
        end
    end
endmodule
`default_nettype wire

// File: rtl/three_wheel_steer_command_top.sv
// Throughput: one command per cycle unless the output stalls or a divisor refresh
// is running; each of three wheels has its own unrolled CORDIC pipeline, one micro-rotation per stage.
// The whole pipe advances when the output register is empty or taken.
// A configuration write holds off input while the serial divider refreshes the divisor.
// Reset (synchronous, active low) clears valid bits and configuration.
`default_nettype none
`include "three_wheel_steer_command_top_defines.svh"
module three_wheel_steer_command_top #(
    parameter int unsigned CORDIC_ITERATIONS = tws_pkg::CordicIterDefault
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // axial_velocity, circ_velocity, pitch_correction, yaw_correction
    input  wire  [63:0] s_axis_tdata,
    // wheel_mode
    input  wire  [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // left_angle, left_speed, right_angle, right_speed, drive_angle, drive_speed
    output logic [95:0] m_axis_tdata,
    // mode_out
    output logic [1:0]  m_axis_tuser,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [0:0]  i_cfg_index,
    input  wire  [9:0]  i_cfg_data
);
    localparam int unsigned Depth = CORDIC_ITERATIONS + 5;
    // floor(2^26 / 1200): reciprocal for radius 0
    localparam logic [15:0] RecipReset = 16'((32'd1 << 26) / 32'd1200);

    logic w_en;
    logic r_busy;
    logic [Depth-1:0] r_vld;
    assign w_en = ~r_vld[Depth-1] | m_axis_tready;
    assign s_axis_tready = w_en & ~r_busy;
    assign m_axis_tvalid = r_vld[Depth-1];
    assign o_cfg_ready = ~r_busy;

    // Configuration registers and derived divider constants
    logic        r_bend_en;
    logic [9:0]  r_radius;
    logic signed [11:0] r_num;
    logic [11:0] r_den;
    logic [15:0] r_recip;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bend_en <= 1'b0;
            r_radius  <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                tws_pkg::REG_BEND_EN: r_bend_en <= i_cfg_data[0];
                tws_pkg::REG_RADIUS:  r_radius  <= i_cfg_data;
                default: ;
            endcase
        end
    end
    always_ff @(posedge i_clk) begin
        r_num   <= 12'sd600 - $signed({2'b00, r_radius});
        r_den   <= 12'd600 + {1'b0, r_radius, 1'b0};
    end

    // Serial divide after each write: r_recip = floor(2^26 / (2*den))
    logic [4:0]  r_div_cnt;
    logic [12:0] r_div_rem;
    logic [12:0] w_div_d;
    logic [13:0] w_div_sh;
    logic        w_div_ge;
    assign w_div_d  = {12'd600 + {1'b0, r_radius, 1'b0}, 1'b0};
    assign w_div_sh = {r_div_rem, (r_div_cnt == 5'd26)};
    assign w_div_ge = (w_div_sh >= {1'b0, w_div_d});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_div_cnt <= '0;
            r_div_rem <= '0;
            r_recip   <= RecipReset;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_busy    <= 1'b1;
            r_div_cnt <= 5'd26;
            r_div_rem <= '0;
            r_recip   <= '0;
        end else if (r_busy) begin
            r_div_rem <= w_div_ge ? 13'(w_div_sh - {1'b0, w_div_d}) : w_div_sh[12:0];
            r_recip   <= {r_recip[14:0], w_div_ge};
            r_div_cnt <= r_div_cnt - 5'd1;
            if (r_div_cnt == 5'd0) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[Depth-2:0], s_axis_tvalid & ~r_busy};
        end
    end

    // Stage 0: form wheel vectors, fold, pre-rotate
    logic signed [15:0] w_ax, w_ci, w_pc, w_yc;
    assign w_ax = s_axis_tdata[15:0];
    assign w_ci = s_axis_tdata[31:16];
    assign w_pc = s_axis_tdata[47:32];
    assign w_yc = s_axis_tdata[63:48];

    tws_pkg::t_lane w_in [3];
    logic signed [17:0] w_axw [3];
    assign w_axw[0] = 18'(w_ax) - 18'(w_yc);
    assign w_axw[1] = 18'(w_ax) + 18'(w_yc);
    assign w_axw[2] = 18'(w_ax) + 18'(w_pc);

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            logic signed [17:0] x, y;
            x = 18'(w_ci);
            y = w_axw[k];
            w_in[k].zero = (x == 0) && (y == 0);
            w_in[k].neg  = (y < 0) || ((y == 0) && (x >= 0));
            if (w_in[k].neg) begin
                x = -x;
                y = -y;
            end
            w_in[k].x = tws_pkg::VecW'(y) <<< 4;
            w_in[k].y = -(tws_pkg::VecW'(x) <<< 4);
            w_in[k].z = $signed({1'b0, tws_pkg::AngHalfPi});
        end
    end

    // Mode line alongside the pipe
    logic [1:0] r_mode [Depth];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mode[0] <= (s_axis_tuser == tws_pkg::MODE_UNUSED) ? tws_pkg::MODE_STOP
                                                                : s_axis_tuser;
            for (int k = 1; k < Depth; k++) r_mode[k] <= r_mode[k-1];
        end
    end

    logic [14:0] w_ang [3];
    logic signed [15:0] w_spd [3];
    genvar g, s;
    generate
        for (g = 0; g < 3; g++) begin : g_wheel
            tws_pkg::t_lane l [CORDIC_ITERATIONS+2];
            tws_pkg::t_lane r_l0;
            always_ff @(posedge i_clk) begin
                if (w_en) r_l0 <= w_in[g];
            end
            assign l[0] = r_l0;
            for (s = 0; s < CORDIC_ITERATIONS; s++) begin : g_stg
                tws_cordic_stage #(.Shift(s)) u_stg (
                    .i_clk(i_clk), .i_en(w_en), .i_lane(l[s]), .o_lane(l[s+1])
                );
            end
            assign l[CORDIC_ITERATIONS+1] = l[CORDIC_ITERATIONS];
            tws_wheel_post u_post (
                .i_clk(i_clk), .i_en(w_en), .i_lane(l[CORDIC_ITERATIONS+1]),
                .i_scale(r_bend_en && (g != 2)), .i_num(r_num), .i_den(r_den),
                .i_recip(r_recip), .o_angle(w_ang[g]), .o_speed(w_spd[g])
            );
        end
    endgenerate

    // Output beat; stop/reset modes override wheel results
    logic w_norm;
    assign w_norm = (r_mode[Depth-1] == tws_pkg::MODE_NORMAL);
    assign m_axis_tuser = r_mode[Depth-1];
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            m_axis_tdata[k*31 +: 15]      = w_norm ? w_ang[k] : tws_pkg::AngHalfPi;
            m_axis_tdata[k*31+15 +: 16]   = w_norm ? w_spd[k] : 16'sd0;
        end
        m_axis_tdata[95:93] = '0;
    end

    `TWS_ASSERT_NEXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `TWS_ASSERT_IMPL(a_mode, i_clk, i_rst_n, m_axis_tvalid, m_axis_tuser != tws_pkg::MODE_UNUSED)
    `TWS_ASSERT_IMPL(a_rdy, i_clk, i_rst_n, !m_axis_tvalid && o_cfg_ready, s_axis_tready)
endmodule
`default_nettype wire

// File: tb/tb_top.sv
`default_nettype none
module tb_top;
    localparam int CordicIters = 14;
    localparam int PipeLatency = CordicIters + 5;
    localparam int StallLimit  = 20000;

    // Result fields, one set per command
    typedef struct {
        logic [1:0]         mode;
        logic [14:0]        l_ang;
        logic signed [15:0] l_spd;
        logic [14:0]        r_ang;
        logic signed [15:0] r_spd;
        logic [14:0]        d_ang;
        logic signed [15:0] d_spd;
    } t_steer_cmd;

    // Steering predictor and store of pending wheel commands
    class steer_scoreboard;
        bit              bend_en;
        logic [9:0]      radius;
        t_steer_cmd      pending[$];
        int              errors;

        function new();
            bend_en = 0;
            radius  = '0;
            errors  = 0;
        endfunction

        // CORDIC vectoring of one wheel vector into angle and signed speed
        function void solve_wheel(longint ax, longint ci, bit assist,
                                  output logic [14:0] ang,
                                  output logic signed [15:0] spd);
            longint x, y, z, t, dx, dy, s, num, den, a, n, q;
            bit     flip_sign;
            if (ax == 0 && ci == 0) begin
                ang = tws_pkg::AngPi;
                spd = 0;
                return;
            end
            x = ci;
            y = ax;
            flip_sign = (y < 0) || (y == 0 && x >= 0);
            if (flip_sign) begin
                x = -x;
                y = -y;
            end
            t = x;
            x = y * 16;
            y = -t * 16;
            z = tws_pkg::AngHalfPi;
            for (int i = 0; i < CordicIters; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (y >= 0) begin
                    x = x + dx;
                    y = y - dy;
                    z = z + atan_step(i);
                end else begin
                    x = x - dx;
                    y = y + dy;
                    z = z - atan_step(i);
                end
            end
            if (z < 1) z = 1;
            if (z > tws_pkg::AngPi) z = tws_pkg::AngPi;
            s = (x * tws_pkg::GainQ16 + (64'sd1 <<< 19)) >>> 20;
            if (flip_sign) s = -s;
            if (assist && bend_en) begin
                num = 600 - longint'(radius);
                den = 600 + 2 * longint'(radius);
                a = s < 0 ? -s : s;
                n = num < 0 ? -num : num;
                q = (2 * a * n + den) / (2 * den);
                s = ((s < 0) != (num < 0)) ? -q : q;
            end
            if (s > 32767) s = 32767;
            if (s < -32768) s = -32768;
            ang = z[14:0];
            spd = s[15:0];
        endfunction

        function longint atan_step(int i);
            case (i)
                0: return 6434;  1: return 3798;  2: return 2007;  3: return 1019;
                4: return 511;   5: return 256;   6: return 128;   7: return 64;
                8: return 32;    9: return 16;    10: return 8;    11: return 4;
                12: return 2;    13: return 1;
                default: return 0;
            endcase
        endfunction

        // Note an accepted command and queue its expected wheel set
        function void note_command(logic [1:0] mode, logic [63:0] d);
            t_steer_cmd e;
            longint ax, ci, pc, yc;
            ax = longint'($signed(d[15:0]));
            ci = longint'($signed(d[31:16]));
            pc = longint'($signed(d[47:32]));
            yc = longint'($signed(d[63:48]));
            if (mode != tws_pkg::MODE_NORMAL) begin
                e.mode = (mode == tws_pkg::MODE_UNUSED) ? tws_pkg::MODE_STOP : mode;
                e.l_ang = tws_pkg::AngHalfPi;
                e.r_ang = tws_pkg::AngHalfPi;
                e.d_ang = tws_pkg::AngHalfPi;
                e.l_spd = 0; e.r_spd = 0; e.d_spd = 0;
            end else begin
                e.mode = tws_pkg::MODE_NORMAL;
                solve_wheel(ax - yc, ci, 1, e.l_ang, e.l_spd);
                solve_wheel(ax + yc, ci, 1, e.r_ang, e.r_spd);
                solve_wheel(ax + pc, ci, 0, e.d_ang, e.d_spd);
            end
            pending.push_back(e);
        endfunction

        function void cmp(string name, longint exp_v, longint act_v);
            if (exp_v != act_v) begin
                errors++;
                $display("%0t: %s mismatch: expected %0d, actual %0d",
                         $time, name, exp_v, act_v);
            end
        endfunction

        // Check one accepted output beat against the oldest expectation
        function void check_result(logic [1:0] mode, logic [95:0] d);
            t_steer_cmd e;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t: unexpected output beat: expected none, actual %h",
                         $time, d);
                return;
            end
            e = pending.pop_front();
            cmp("mode_out", e.mode, mode);
            cmp("left_angle", e.l_ang, d[14:0]);
            cmp("left_speed", e.l_spd, $signed(d[30:15]));
            cmp("right_angle", e.r_ang, d[45:31]);
            cmp("right_speed", e.r_spd, $signed(d[61:46]));
            cmp("drive_angle", e.d_ang, d[76:62]);
            cmp("drive_speed", e.d_spd, $signed(d[92:77]));
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [95:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        i_cfg_valid = 0;
    logic        o_cfg_ready;
    logic [0:0]  i_cfg_index = '0;
    logic [9:0]  i_cfg_data = '0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_off = 0;
    int quiet_cycles = 0;
    steer_scoreboard sb = new();

    always #4 i_clk = ~i_clk;

    three_wheel_steer_command_top #(.CORDIC_ITERATIONS(CordicIters)) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // Receiver: random stalls, plus a long hold-off when requested
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tuser, m_axis_tdata);
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_axis_tready <= 0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog on cycles with no beat accepted on any channel
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= StallLimit) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Offer one command and hold it until accepted
    task automatic send_command(logic [1:0] mode, logic [15:0] ax, logic [15:0] ci,
                                logic [15:0] pc, logic [15:0] yc);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {yc, pc, ci, ax};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_command(mode, {yc, pc, ci, ax});
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (PipeLatency + 4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [9:0] val);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 0;
        if (idx == tws_pkg::REG_BEND_EN) sb.bend_en = val[0];
        else sb.radius = val;
        @(posedge i_clk);
    endtask

    // Random speed: mostly moderate, sometimes extremes or zero
    function automatic logic [15:0] rand_speed();
        case ($urandom_range(9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3, 4: return 16'($urandom());
            default: return 16'($signed($urandom_range(4000)) - 2000);
        endcase
    endfunction

    task automatic random_batch(int count);
        logic [1:0] mode;
        for (int k = 0; k < count; k++) begin
            mode = ($urandom_range(9) < 7) ? tws_pkg::MODE_NORMAL : 2'($urandom_range(3));
            send_command(mode, rand_speed(), rand_speed(), rand_speed(), rand_speed());
        end
    endtask

    initial begin
        logic [9:0] radii[5];
        radii = '{10'd0, 10'd300, 10'd600, 10'd1023, 10'd77};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: all modes, extremes, zero vector, angle zero, folding
        send_command(tws_pkg::MODE_STOP, 16'h1234, 16'h4321, 16'h0100, 16'h0100);
        send_command(tws_pkg::MODE_RESET, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
        send_command(tws_pkg::MODE_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_command(tws_pkg::MODE_NORMAL, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_command(tws_pkg::MODE_NORMAL, 16'h0000, 16'h0100, 16'h0000, 16'h0000);
        send_command(tws_pkg::MODE_NORMAL, 16'h0000, 16'hFF00, 16'h0000, 16'h0000);
        send_command(tws_pkg::MODE_NORMAL, 16'h0100, 16'h0000, 16'h0000, 16'h0000);
        send_command(tws_pkg::MODE_NORMAL, 16'hFF00, 16'h0000, 16'h0000, 16'h0000);
        send_command(tws_pkg::MODE_NORMAL, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_command(tws_pkg::MODE_NORMAL, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_command(tws_pkg::MODE_NORMAL, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
        send_command(tws_pkg::MODE_NORMAL, 16'h0100, 16'h0100, 16'hFF00, 16'h0100);
        send_command(tws_pkg::MODE_NORMAL, 16'hFF00, 16'h0100, 16'h0200, 16'hFF00);
        send_command(tws_pkg::MODE_NORMAL, 16'h0001, 16'hFFFF, 16'h0000, 16'h0001);
        drain();

        // Bend scaling extremes, then random at several settings and idle mixes
        write_reg(tws_pkg::REG_BEND_EN, 10'd1);
        for (int r = 0; r < 5; r++) begin
            write_reg(tws_pkg::REG_RADIUS, radii[r]);
            send_command(tws_pkg::MODE_NORMAL, 16'h7FFF, 16'h8000, 16'h0000, 16'h7FFF);
            send_command(tws_pkg::MODE_NORMAL, 16'h0300, 16'hFD00, 16'h0000, 16'hFF80);
            case (r % 3)
                0: begin send_idle_pct = 29; recv_idle_pct = 50; end
                1: begin send_idle_pct = 50; recv_idle_pct = 29; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            random_batch(160);
            drain();
        end

        // Fill the pipe against a stalled receiver
        send_idle_pct = 0;
        hold_off = 300;
        random_batch(100);
        drain();
        write_reg(tws_pkg::REG_BEND_EN, 10'd0);
        write_reg(tws_pkg::REG_RADIUS, 10'd0);
        random_batch(120);
        drain();

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
